@@ rtl/assert_macros.svh @@
// Assertion macros for the lexer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define SLU_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lexer assertion failed");

// Check a property on every rising clock edge, reset included
`define SLU_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("lexer assertion failed");

`endif

@@ rtl/slu_pkg.sv @@
// Types, token kinds and keyword table for the source code lexer
package slu_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int MAX_TOKENS  = 3;
  localparam int QW          = $clog2(QUEUE_DEPTH);

  localparam logic [5:0] K_DOT        = 6'd5;
  localparam logic [5:0] K_BANG       = 6'd10;
  localparam logic [5:0] K_EQUAL      = 6'd12;
  localparam logic [5:0] K_LESS       = 6'd14;
  localparam logic [5:0] K_GREATER    = 6'd16;
  localparam logic [5:0] K_SLASH      = 6'd18;
  localparam logic [5:0] K_IDENT      = 6'd19;
  localparam logic [5:0] K_STRING     = 6'd20;
  localparam logic [5:0] K_NUMBER     = 6'd21;
  localparam logic [5:0] K_KEYWORD0   = 6'd22;
  localparam logic [5:0] K_END        = 6'd38;
  localparam logic [5:0] K_ERR_CHAR   = 6'd39;
  localparam logic [5:0] K_ERR_STRING = 6'd40;

  localparam logic [3:0] KEYWORD_MAX_LEN = 4'd8;

  typedef enum logic [3:0] {
    M_IDLE, M_BANG, M_EQUAL, M_LESS, M_GREATER, M_SLASH, M_COMMENT,
    M_STRING, M_NUMBER, M_NUM_DOT, M_FRACTION, M_WORD
  } mode_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic [15:0] line;
    logic        last;
  } token_t;

  typedef struct packed {
    logic [1:0]       cnt;
    token_t [2:0]     toks;
  } push_t;

  function automatic logic [63:0] kw_text(input logic [3:0] k);
    logic [63:0] t;
    case (k)
      4'd0:    t = 64'(24'h646e61);
      4'd1:    t = 64'(40'h7373616c63);
      4'd2:    t = 64'(32'h65736c65);
      4'd3:    t = 64'(40'h65736c6166);
      4'd4:    t = 64'(24'h726f66);
      4'd5:    t = 64'h6e6f6974636e7566;
      4'd6:    t = 64'(16'h6669);
      4'd7:    t = 64'(32'h6c6c756e);
      4'd8:    t = 64'(16'h726f);
      4'd9:    t = 64'(40'h746e697270);
      4'd10:   t = 64'(48'h6e7275746572);
      4'd11:   t = 64'(40'h7265707573);
      4'd12:   t = 64'(32'h73696874);
      4'd13:   t = 64'(32'h65757274);
      4'd14:   t = 64'(24'h726176);
      default: t = 64'(40'h656c696877);
    endcase
    return t;
  endfunction

  function automatic logic [3:0] kw_len(input logic [3:0] k);
    logic [3:0] l;
    case (k)
      4'd0, 4'd4, 4'd14:                     l = 4'd3;
      4'd2, 4'd7, 4'd12, 4'd13:              l = 4'd4;
      4'd1, 4'd3, 4'd9, 4'd11, 4'd15:        l = 4'd5;
      4'd10:                                 l = 4'd6;
      4'd5:                                  l = 4'd8;
      default:                               l = 4'd2;
    endcase
    return l;
  endfunction

endpackage

@@ rtl/source_code_lexer_unit.sv @@
// Top level of the source code lexer: byte stream in, token stream out
// One source byte (or the end-of-text item) is accepted per cycle. An accepted item is held in
// the input register while the scanner decides on it and writes the zero to three tokens
// it causes into an eight-entry token queue; the first token is offered once the queue has
// registered it. in_tready stays high while the queue, counting what the scanner is writing
// this cycle, holds at most three tokens, so a stalled result side holds the input back
// only once tokens pile up; with the result side always ready the rate is one byte per
// cycle. Offsets count bytes of the current text and saturate; after end of text the next
// byte starts at offset 0 on line 1.
module source_code_lexer_unit
  import slu_pkg::*;
#(
  parameter int OFFSET_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // char_code
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // token_kind, start_offset, lexeme_length, line_number
  output logic        out_tlast   // last_of_run
);

  push_t       push;
  logic [QW:0] count;
  token_t      head;
  logic        accept;

  assign in_tready = rst_n && (({1'b0, count} + (QW+2)'(push.cnt))
                     <= (QW+2)'(QUEUE_DEPTH - 2 * MAX_TOKENS + 1));
  assign accept    = in_tvalid && in_tready;

  slu_scan #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .char_in (in_tdata),
    .eot_in  (in_tlast),
    .push    (push)
  );

  slu_tok_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (out_tready),
    .count (count),
    .valid (out_tvalid),
    .head  (head)
  );

  assign out_tdata = {2'b00, head.line, head.len, head.start, head.kind};
  assign out_tlast = head.last;

endmodule

@@ rtl/slu_scan.sv @@
// Input register, scanner state and per-byte token decision
module slu_scan
  import slu_pkg::*;
#(
  parameter int OFFSET_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] char_in,
  input  logic       eot_in,
  output push_t      push
);

  localparam int W = OFFSET_WIDTH;

  logic          valid_r;
  logic [7:0]    char_r;
  logic          eot_r;
  mode_t         mode_r, mode_nxt;
  logic [W-1:0]  pos_r, pos_nxt;
  logic [W-1:0]  begin_r, begin_nxt;
  logic [15:0]   line_r, line_nxt;
  logic [63:0]   prefix_r, prefix_nxt;
  logic [3:0]    wlen_r, wlen_nxt;

  logic [5:0]    wkind;
  logic [1:0]    fl_cnt;
  token_t        fl_a, fl_b;
  logic [W-1:0]  pm1;
  logic          rescan;
  logic [1:0]    n;
  token_t [2:0]  toks;

  function automatic logic [15:0] sat16(input logic [W:0] v);
    logic [32:0] x;
    x = 33'(v);
    return (x > 33'h0FFFF) ? 16'hFFFF : x[15:0];
  endfunction

  function automatic logic [W-1:0] clamp_sub(input logic [W-1:0] a, input logic [W-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  function automatic token_t mk(input logic [5:0] kind, input logic [W-1:0] start,
                                input logic [W:0] len, input logic [15:0] line);
    token_t t;
    t.kind  = kind;
    t.start = sat16({1'b0, start});
    t.len   = sat16(len);
    t.line  = line;
    t.last  = 1'b0;
    return t;
  endfunction

  function automatic logic digit_char(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic alpha_char(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      mode_r   <= M_IDLE;
      pos_r    <= '0;
      begin_r  <= '0;
      line_r   <= 16'd1;
      prefix_r <= '0;
      wlen_r   <= '0;
    end else begin
      valid_r  <= accept;
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      begin_r  <= begin_nxt;
      line_r   <= line_nxt;
      prefix_r <= prefix_nxt;
      wlen_r   <= wlen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      char_r <= char_in;
      eot_r  <= eot_in;
    end
  end

  always_comb begin
    wkind = K_IDENT;
    for (int k = 0; k < 16; k++) begin
      if (wlen_r == kw_len(4'(k)) && prefix_r == kw_text(4'(k))) begin
        wkind = K_KEYWORD0 + 6'(k);
      end
    end
    if (wlen_r > KEYWORD_MAX_LEN) begin
      wkind = K_IDENT;
    end
  end

  always_comb begin
    pm1    = clamp_sub(pos_r, W'(1));
    fl_cnt = 2'd0;
    fl_a   = '0;
    fl_b   = '0;
    case (mode_r)
      M_BANG: begin
        fl_cnt = 2'd1; fl_a = mk(K_BANG, begin_r, (W+1)'(1), line_r);
      end
      M_EQUAL: begin
        fl_cnt = 2'd1; fl_a = mk(K_EQUAL, begin_r, (W+1)'(1), line_r);
      end
      M_LESS: begin
        fl_cnt = 2'd1; fl_a = mk(K_LESS, begin_r, (W+1)'(1), line_r);
      end
      M_GREATER: begin
        fl_cnt = 2'd1; fl_a = mk(K_GREATER, begin_r, (W+1)'(1), line_r);
      end
      M_SLASH: begin
        fl_cnt = 2'd1; fl_a = mk(K_SLASH, begin_r, (W+1)'(1), line_r);
      end
      M_NUMBER, M_FRACTION: begin
        fl_cnt = 2'd1;
        fl_a   = mk(K_NUMBER, begin_r, {1'b0, clamp_sub(pos_r, begin_r)}, line_r);
      end
      M_NUM_DOT: begin
        fl_cnt = 2'd2;
        fl_a   = mk(K_NUMBER, begin_r, {1'b0, clamp_sub(pm1, begin_r)}, line_r);
        fl_b   = mk(K_DOT, pm1, (W+1)'(1), line_r);
      end
      M_WORD: begin
        fl_cnt = 2'd1;
        fl_a   = mk(wkind, begin_r, {1'b0, clamp_sub(pos_r, begin_r)}, line_r);
      end
      M_STRING: begin
        fl_cnt = 2'd1;
        fl_a   = mk(K_ERR_STRING, begin_r, {1'b0, clamp_sub(pos_r, begin_r)}, line_r);
      end
      default: begin
        fl_cnt = 2'd0;
      end
    endcase
  end

  always_comb begin
    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    begin_nxt  = begin_r;
    line_nxt   = line_r;
    prefix_nxt = prefix_r;
    wlen_nxt   = wlen_r;
    rescan     = 1'b0;
    n          = 2'd0;
    toks       = '0;
    if (valid_r) begin
      if (eot_r) begin
        toks[0]    = fl_a;
        toks[1]    = fl_b;
        n          = fl_cnt;
        toks[n]    = mk(K_END, pos_r, '0, line_r);
        n          = n + 2'd1;
        mode_nxt   = M_IDLE;
        pos_nxt    = '0;
        begin_nxt  = '0;
        line_nxt   = 16'd1;
        prefix_nxt = '0;
        wlen_nxt   = '0;
      end else begin
        case (mode_r)
          M_BANG, M_EQUAL, M_LESS, M_GREATER: begin
            if (char_r == "=") begin
              toks[0]  = mk(fl_a.kind + 6'd1, begin_r, (W+1)'(2), line_r);
              n        = 2'd1;
              mode_nxt = M_IDLE;
            end else begin
              rescan = 1'b1;
            end
          end
          M_SLASH: begin
            if (char_r == "/") mode_nxt = M_COMMENT;
            else rescan = 1'b1;
          end
          M_COMMENT: begin
            if (char_r == "\n") rescan = 1'b1;
          end
          M_STRING: begin
            if (char_r == "\n" && line_r != 16'hFFFF) line_nxt = line_r + 16'd1;
            if (char_r == "\"") begin
              toks[0]  = mk(K_STRING, begin_r, {1'b0, clamp_sub(pos_r, begin_r)} + (W+1)'(1),
                            line_r);
              n        = 2'd1;
              mode_nxt = M_IDLE;
            end
          end
          M_NUMBER: begin
            if (char_r == ".") mode_nxt = M_NUM_DOT;
            else if (!digit_char(char_r)) rescan = 1'b1;
          end
          M_NUM_DOT: begin
            if (digit_char(char_r)) mode_nxt = M_FRACTION;
            else rescan = 1'b1;
          end
          M_FRACTION: begin
            if (!digit_char(char_r)) rescan = 1'b1;
          end
          M_WORD: begin
            if (alpha_char(char_r) || digit_char(char_r)) begin
              for (int i = 0; i < 8; i++) begin
                if (wlen_r == 4'(i)) prefix_nxt[8*i +: 8] = char_r;
              end
              if (wlen_r != 4'd15) wlen_nxt = wlen_r + 4'd1;
            end else begin
              rescan = 1'b1;
            end
          end
          default: begin
            rescan = 1'b1;
          end
        endcase

        if (rescan) begin
          toks[0]   = fl_a;
          toks[1]   = fl_b;
          n         = fl_cnt;
          mode_nxt  = M_IDLE;
          begin_nxt = pos_r;
          case (char_r)
            "(", ")", "{", "}", ",", ".", "-", "+", ";", "*": begin
              toks[n] = mk((char_r == "(") ? 6'd0 : (char_r == ")") ? 6'd1 :
                           (char_r == "{") ? 6'd2 : (char_r == "}") ? 6'd3 :
                           (char_r == ",") ? 6'd4 : (char_r == ".") ? 6'd5 :
                           (char_r == "-") ? 6'd6 : (char_r == "+") ? 6'd7 :
                           (char_r == ";") ? 6'd8 : 6'd9,
                           pos_r, (W+1)'(1), line_r);
              n = n + 2'd1;
            end
            "!":  mode_nxt = M_BANG;
            "=":  mode_nxt = M_EQUAL;
            "<":  mode_nxt = M_LESS;
            ">":  mode_nxt = M_GREATER;
            "/":  mode_nxt = M_SLASH;
            " ", 8'h0d, "\t": mode_nxt = M_IDLE;
            "\n": begin
              if (line_r != 16'hFFFF) line_nxt = line_r + 16'd1;
            end
            "\"": mode_nxt = M_STRING;
            default: begin
              if (digit_char(char_r)) begin
                mode_nxt = M_NUMBER;
              end else if (alpha_char(char_r)) begin
                mode_nxt   = M_WORD;
                prefix_nxt = 64'(char_r);
                wlen_nxt   = 4'd1;
              end else begin
                toks[n] = mk(K_ERR_CHAR, pos_r, (W+1)'(1), line_r);
                n       = n + 2'd1;
              end
            end
          endcase
        end

        if (pos_r != {W{1'b1}}) pos_nxt = pos_r + W'(1);
      end
    end
    if (n != 2'd0) toks[n - 2'd1].last = 1'b1;
    push.cnt  = n;
    push.toks = toks;
  end

endmodule

@@ rtl/slu_tok_queue.sv @@
// Token queue between the scanner and the result channel
`include "assert_macros.svh"
module slu_tok_queue
  import slu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  push_t       push,
  input  logic        pop,
  output logic [QW:0] count,
  output logic        valid,
  output token_t      head
);

  token_t [QUEUE_DEPTH-1:0] mem;
  logic [QW-1:0] head_r, head_nxt;
  logic [QW-1:0] tail_r, tail_nxt;
  logic [QW:0]   count_r, count_nxt;
  logic          do_pop;

  assign do_pop    = pop && (count_r != '0);
  assign head_nxt  = do_pop ? head_r + QW'(1) : head_r;
  assign tail_nxt  = tail_r + QW'(push.cnt);
  assign count_nxt = count_r + (QW+1)'(push.cnt) - (QW+1)'(do_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_TOKENS; i++) begin
      if (2'(i) < push.cnt) mem[tail_r + QW'(i)] <= push.toks[i];
    end
  end

  assign count = count_r;
  assign valid = (count_r != '0);
  assign head  = mem[head_r];

  `SLU_ASSERT(a_no_overflow, clk, rst_n,
    ({1'b0, count_r} + (QW+2)'(push.cnt)) <= (QW+2)'(QUEUE_DEPTH + 1))
  `SLU_ASSERT(a_pop_only, clk, rst_n,
    (do_pop && push.cnt == 2'd0) |=> (count_r == $past(count_r) - (QW+1)'(1)))
  `SLU_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> (count_r == '0))

endmodule

@@ dv/tb_source_code_lexer_unit.sv @@
// Self-checking testbench for the source code lexer: random and directed source texts
module tb_source_code_lexer_unit;
  import slu_pkg::*;

  class lex_scoreboard;
    mode_t       mode;
    int          pos, tbeg, line, wlen;
    logic [63:0] prefix;
    token_t      pending[$];
    logic [63:0] kw_word[16];
    int          kw_size[16];
    int          errors, tokens, texts;
    string       kw_names[16] = '{"and", "class", "else", "false", "for", "function", "if",
                                  "null", "or", "print", "return", "super", "this", "true",
                                  "var", "while"};
    string       punct = "(){},.-+;*";

    function new();
      for (int k = 0; k < 16; k++) begin
        kw_word[k] = '0;
        kw_size[k] = kw_names[k].len();
        for (int i = 0; i < kw_size[k] && i < 8; i++)
          kw_word[k][8*i +: 8] = kw_names[k][i];
      end
      restart();
    endfunction

    function void restart();
      mode = M_IDLE; pos = 0; tbeg = 0; line = 1; prefix = '0; wlen = 0;
    endfunction

    function int sat(int v);
      return v > 65535 ? 65535 : v;
    endfunction

    function int clamp(int a, int b);
      return a > b ? a - b : 0;
    endfunction

    function void emit(logic [5:0] kind, int start, int len);
      token_t t;
      t.kind = kind; t.start = sat(start); t.len = sat(len);
      t.line = line; t.last = 1'b0;
      pending.push_back(t);
    endfunction

    function logic [5:0] word_kind();
      if (wlen > KEYWORD_MAX_LEN) return K_IDENT;
      for (int k = 0; k < 16; k++)
        if (kw_size[k] == wlen && kw_word[k] == prefix) return K_KEYWORD0 + k;
      return K_IDENT;
    endfunction

    function void line_up();
      if (line < 65535) line++;
    endfunction

    function void flush(int p);
      case (mode)
        M_BANG:    emit(K_BANG, tbeg, 1);
        M_EQUAL:   emit(K_EQUAL, tbeg, 1);
        M_LESS:    emit(K_LESS, tbeg, 1);
        M_GREATER: emit(K_GREATER, tbeg, 1);
        M_SLASH:   emit(K_SLASH, tbeg, 1);
        M_NUMBER, M_FRACTION: emit(K_NUMBER, tbeg, clamp(p, tbeg));
        M_NUM_DOT: begin
          emit(K_NUMBER, tbeg, clamp(clamp(p, 1), tbeg));
          emit(K_DOT, clamp(p, 1), 1);
        end
        M_WORD:    emit(word_kind(), tbeg, clamp(p, tbeg));
        M_STRING:  emit(K_ERR_STRING, tbeg, clamp(p, tbeg));
        default: ;
      endcase
      mode = M_IDLE;
    endfunction

    function bit digit_char(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit alpha_char(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function void scan_fresh(logic [7:0] c, int p);
      tbeg = p;
      for (int k = 0; k < 10; k++)
        if (c == punct[k]) begin
          emit(k, p, 1);
          return;
        end
      if (c == "!") mode = M_BANG;
      else if (c == "=") mode = M_EQUAL;
      else if (c == "<") mode = M_LESS;
      else if (c == ">") mode = M_GREATER;
      else if (c == "/") mode = M_SLASH;
      else if (c == " " || c == 8'h0d || c == 8'h09) ;
      else if (c == 8'h0a) line_up();
      else if (c == "\"") mode = M_STRING;
      else if (digit_char(c)) mode = M_NUMBER;
      else if (alpha_char(c)) begin
        mode = M_WORD; prefix = 64'(c); wlen = 1;
      end else emit(K_ERR_CHAR, p, 1);
    endfunction

    function void note_item(logic [7:0] c, logic eot);
      int p, n0;
      bit rescan;
      p = pos; n0 = pending.size(); rescan = 0;
      if (eot) begin
        flush(p);
        emit(K_END, p, 0);
        pending[$].last = 1'b1;
        restart();
        texts++;
        return;
      end
      case (mode)
        M_BANG, M_EQUAL, M_LESS, M_GREATER:
          if (c == "=") begin
            emit((mode == M_BANG ? K_BANG : mode == M_EQUAL ? K_EQUAL :
                  mode == M_LESS ? K_LESS : K_GREATER) + 6'd1, tbeg, 2);
            mode = M_IDLE;
          end else rescan = 1;
        M_SLASH: if (c == "/") mode = M_COMMENT; else rescan = 1;
        M_COMMENT: if (c == 8'h0a) begin mode = M_IDLE; rescan = 1; end
        M_STRING: begin
          if (c == 8'h0a) line_up();
          if (c == "\"") begin
            emit(K_STRING, tbeg, clamp(p, tbeg) + 1);
            mode = M_IDLE;
          end
        end
        M_NUMBER: if (c == ".") mode = M_NUM_DOT; else if (!digit_char(c)) rescan = 1;
        M_NUM_DOT: if (digit_char(c)) mode = M_FRACTION; else rescan = 1;
        M_FRACTION: if (!digit_char(c)) rescan = 1;
        M_WORD:
          if (alpha_char(c) || digit_char(c)) begin
            if (wlen < 8) prefix[8*wlen +: 8] = c;
            if (wlen < 15) wlen++;
          end else rescan = 1;
        default: begin mode = M_IDLE; rescan = 1; end
      endcase
      if (rescan) begin
        flush(p);
        scan_fresh(c, p);
      end
      if (pos < 65535) pos++;
      if (pending.size() > n0) pending[$].last = 1'b1;
    endfunction

    function void check(logic [55:0] data, logic last);
      token_t e;
      if (pending.size() == 0) begin
        $error("unexpected token: tdata %h tlast %b", data, last);
        errors++;
        return;
      end
      e = pending.pop_front();
      tokens++;
      if (data[5:0] !== e.kind) begin
        $error("token_kind: expected %0d, actual %0d", e.kind, data[5:0]); errors++;
      end
      if (data[21:6] !== e.start) begin
        $error("start_offset: expected %0d, actual %0d", e.start, data[21:6]); errors++;
      end
      if (data[37:22] !== e.len) begin
        $error("lexeme_length: expected %0d, actual %0d", e.len, data[37:22]); errors++;
      end
      if (data[53:38] !== e.line) begin
        $error("line_number: expected %0d, actual %0d", e.line, data[53:38]); errors++;
      end
      if (last !== e.last) begin
        $error("last_of_run: expected %0d, actual %0d", e.last, last); errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        out_tlast;

  lex_scoreboard sb = new();
  int          gap_pct, stall_pct, hold_off, cycles, sent;
  logic [7:0]  src[$];
  string       word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  string       ops[12] = '{"!", "!=", "=", "==", "<", "<=", ">", ">=", "/", "(", ";", "*"};

  source_code_lexer_unit uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check(out_tdata, out_tlast);
      if (hold_off > 0) begin
        hold_off--;
        out_tready <= 1'b0;
      end else out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_item(logic [7:0] c, logic eot);
    if ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= eot;
    do @(posedge clk); while (!in_tready);
    sb.note_item(c, eot);
    sent++;
  endtask

  task automatic send_text(bit close);
    foreach (src[i]) send_item(src[i], 1'b0);
    if (close) send_item(8'($urandom_range(255)), 1'b1);
    src.delete();
  endtask

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) src.push_back(s[i]);
  endfunction

  function automatic void add_digits(int n);
    repeat (n) src.push_back(8'("0" + $urandom_range(9)));
  endfunction

  function automatic void add_lexeme();
    case ($urandom_range(11))
      0: begin
        add_str(sb.kw_names[$urandom_range(15)]);
        if ($urandom_range(3) == 0) src.push_back(word_chars[$urandom_range(62)]);
      end
      1: begin
        src.push_back(word_chars[$urandom_range(52)]);
        repeat ($urandom_range(13)) src.push_back(word_chars[$urandom_range(62)]);
      end
      2: add_digits($urandom_range(1, 5));
      3: begin add_digits($urandom_range(1, 3)); add_str("."); add_digits($urandom_range(1, 3)); end
      4: begin add_digits($urandom_range(1, 3)); add_str("."); src.push_back(ops[$urandom_range(11)][0]); end
      5: begin
        add_str("\"");
        repeat ($urandom_range(6))
          src.push_back($urandom_range(4) == 0 ? 8'h0a : 8'($urandom_range(32, 126)));
        if (src[$] == "\"") src.push_back("x");
        add_str("\"");
      end
      6: add_str(ops[$urandom_range(11)]);
      7: begin
        add_str("//");
        repeat ($urandom_range(5)) src.push_back(8'($urandom_range(32, 126)));
        src.push_back(8'h0a);
      end
      8: src.push_back($urandom_range(1) ? 8'h0a : ($urandom_range(1) ? 8'h09 : 8'h0d));
      9: src.push_back(8'($urandom_range(255)));
      10: begin add_str("/"); src.push_back(8'($urandom_range(32, 126))); end
      default: src.push_back(sb.punct[$urandom_range(9)]);
    endcase
    if ($urandom_range(1)) add_str(" ");
  endfunction

  task automatic random_phase(int gap, int stall, bit squeeze);
    int goal;
    gap_pct = gap; stall_pct = stall;
    if (squeeze) hold_off = 400;
    goal = sent + 80;
    while (sent < goal) begin
      repeat ($urandom_range(3, 15)) add_lexeme();
      case ($urandom_range(7))
        0: begin add_str("\"ab"); src.push_back(8'h0a); end
        1: add_str("12.");
        2: add_str("// tail");
        default: ;
      endcase
      send_text(1'b1);
    end
    in_tvalid <= 1'b0;
    wait (sb.pending.size() == 0);
  endtask

  initial begin
    gap_pct = 0; stall_pct = 0; hold_off = 0; sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    add_str("(){},.-+;*!!= ==<<=>>=/");
    send_text(1'b1);
    add_str("//c"); src.push_back(8'h0a); add_str("3.5 7.a _Zz9 functions@");
    src.push_back(8'h00); src.push_back(8'hff);
    send_text(1'b1);
    add_str("x\"s"); src.push_back(8'h0a);
    send_text(1'b1);

    random_phase(0, 0, 1'b1);
    random_phase(63, 0, 1'b0);
    random_phase(0, 63, 1'b0);
    random_phase(37, 37, 1'b0);

    gap_pct = 0; stall_pct = 0;
    add_str("\"q");
    send_text(1'b1);
    in_tvalid <= 1'b0;
    wait (sb.pending.size() == 0);
    repeat (20) @(posedge clk);

    $display("Sent %0d items in %0d texts, checked %0d tokens", sent, sb.texts, sb.tokens);
    $display("Covered all idle mixes and a long output hold-off that fills the token queue");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
